// ----- rtl/hbds_pkg.sv -----
// Package for the hash bucket block: FSM state codes, opcodes, register
// indexes and the per-cell control struct. No dependencies.
`default_nettype none
package hbds_pkg;

  localparam int CNT_W  = 5;
  localparam int WORD_W = 64;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_SPLIT  = 2'd2;

  localparam logic REG_TUPLE_WORDS = 1'b0;
  localparam logic REG_CAPACITY    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_COUNT,
    S_SPLIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic en;
    logic sel_alt;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/hbds_cell.sv -----
// One cell of the entry chain: holds a hash and its tuple words.
// Depends on hbds_pkg for the cell control struct.
`default_nettype none
module hbds_cell
  import hbds_pkg::*;
#(
  parameter int EW = 320
) (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire [EW-1:0]   nbr,
  input  wire [EW-1:0]   alt,
  output logic [EW-1:0]  q
);

  logic [EW-1:0] ent_r;

  // Each step a cell takes its neighbor's entry, or the shared bus when it
  // is the slot being written.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ent_r <= ctl.sel_alt ? alt : nbr;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

// ----- rtl/hash_bucket_dedup_split_top.sv -----
// Top level of the hash bucket: FSM, staging buffer, config registers and
// the chain of entry cells. Depends on hbds_pkg and hbds_cell.
`default_nettype none
// One hash bucket for duplicate removal. Tuple words are taken one beat at a
// time while busy is low; a beat without in_word_last is only staged. The
// beat with in_word_last starts the operation and holds busy high until it
// is done. Entries live in a chain of cells that shifts toward cell 0 each
// step, so every scan walks the stored entries through cell 0, one entry per
// cycle except while a split emits the words of a moved entry. A lookup or
// insert returns one result. A split takes one counting pass to learn the
// count that remains, then a second pass that emits each moved word, and one
// closing step. Results come out with out_valid high for a single cycle each;
// the receiver cannot stall them.
module hash_bucket_dedup_split_top
  import hbds_pkg::*;
#(
  parameter int MAX_ENTRIES     = 16,
  parameter int MAX_TUPLE_WORDS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   in_func,
  input  wire logic [63:0]  in_hash,
  input  wire logic [63:0]  in_word,
  input  wire logic         in_word_last,
  input  wire logic [63:0]  in_split_mask,
  input  wire logic [63:0]  in_split_suffix,
  output logic              out_valid,
  output logic              out_found,
  output logic              out_bucket_full,
  output logic              out_moved_valid,
  output logic [63:0]       out_moved_hash,
  output logic [63:0]       out_moved_word,
  output logic              out_run_last,
  output logic [4:0]        out_remaining_count,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int EW = WORD_W * (MAX_TUPLE_WORDS + 1);
  localparam int SW = (MAX_TUPLE_WORDS > 1) ? $clog2(MAX_TUPLE_WORDS) : 1;

  // Configuration registers.
  logic [2:0] tw_r;
  logic [4:0] cap_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r  <= 3'd1;
      cap_r <= 5'd16;
    end else if (wr_en) begin
      if (paddr[2] == REG_TUPLE_WORDS) tw_r  <= pwdata[2:0];
      if (paddr[2] == REG_CAPACITY)    cap_r <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_TUPLE_WORDS: prdata[2:0] = tw_r;
      REG_CAPACITY:    prdata[4:0] = cap_r;
      default:         prdata      = '0;
    endcase
  end

  // Effective settings with out-of-range values clamped.
  logic [2:0] n_eff;
  logic [4:0] cap_eff;

  always_comb begin
    if (tw_r == 3'd0) n_eff = 3'd1;
    else if (tw_r > 3'(MAX_TUPLE_WORDS)) n_eff = 3'(MAX_TUPLE_WORDS);
    else n_eff = tw_r;
    if (cap_r == 5'd0) cap_eff = 5'd1;
    else if (cap_r > 5'(MAX_ENTRIES)) cap_eff = 5'(MAX_ENTRIES);
    else cap_eff = cap_r;
  end

  // Control and operation registers.
  state_t          st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] t_r, t_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] mv_r, mv_nxt;
  logic [SW-1:0]    w_r, w_nxt;
  logic [SW-1:0]    sidx_r, sidx_nxt;
  logic             fnd_r, fnd_nxt;
  logic [1:0]       func_r;
  logic [63:0]      h_r, mask_r, suf_r;
  logic [63:0]      stg_r [MAX_TUPLE_WORDS];

  logic        ov_r, ov_nxt;
  logic        of_r, of_nxt;
  logic        ons_r, ons_nxt;
  logic        omv_r, omv_nxt;
  logic [63:0] oh_r, oh_nxt;
  logic [63:0] ow_r, ow_nxt;
  logic        orl_r, orl_nxt;
  logic [4:0]  orc_r, orc_nxt;

  logic accept, stg_clr;
  assign busy   = (st_r != S_IDLE);
  assign accept = start & ~busy;

  // Cell chain.
  cell_ctl_t   ctl [MAX_ENTRIES];
  logic [EW-1:0] cq [MAX_ENTRIES];
  logic [EW-1:0] alt;
  logic [EW-1:0] stg_ent;
  logic          alt_stg;
  logic [CNT_W-1:0] wsel;
  logic          shift_en, wsel_en;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_ENTRIES;
    always_comb begin
      ctl[i].en      = shift_en | (wsel_en & (wsel == CNT_W'(i)));
      ctl[i].sel_alt = wsel_en & (wsel == CNT_W'(i));
    end
    hbds_cell #(.EW(EW)) u_cell (
      .clk (clk),
      .ctl (ctl[i]),
      .nbr (cq[NB]),
      .alt (alt),
      .q   (cq[i])
    );
  end

  always_comb begin
    stg_ent = '0;
    stg_ent[63:0] = h_r;
    for (int j = 0; j < MAX_TUPLE_WORDS; j++) begin
      stg_ent[WORD_W*(j+1) +: WORD_W] = stg_r[j];
    end
  end

  assign alt = alt_stg ? stg_ent : cq[0];

  // Compare of the entry sitting in cell 0 against the staged tuple.
  logic [63:0] head_hash;
  logic        head_match, head_moves;
  assign head_hash  = cq[0][63:0];
  assign head_moves = ((head_hash & mask_r) == suf_r);

  always_comb begin
    head_match = (head_hash == h_r);
    for (int j = 0; j < MAX_TUPLE_WORDS; j++) begin
      if ((3'(j) < n_eff) && (cq[0][WORD_W*(j+1) +: WORD_W] != stg_r[j])) begin
        head_match = 1'b0;
      end
    end
  end

  logic [CNT_W-1:0] keep_pos;
  assign keep_pos = cnt_r - CNT_W'(1) - t_r + k_r;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    t_nxt    = t_r;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    mv_nxt   = mv_r;
    w_nxt    = w_r;
    fnd_nxt  = fnd_r;
    shift_en = 1'b0;
    wsel_en  = 1'b0;
    wsel     = keep_pos;
    alt_stg  = 1'b0;
    stg_clr  = 1'b0;
    ov_nxt   = 1'b0;
    of_nxt   = 1'b0;
    ons_nxt  = 1'b0;
    omv_nxt  = 1'b0;
    oh_nxt   = '0;
    ow_nxt   = '0;
    orl_nxt  = 1'b0;
    orc_nxt  = cnt_r;
    case (st_r)
      S_IDLE: begin
        if (accept && in_word_last) begin
          t_nxt   = '0;
          k_nxt   = '0;
          fnd_nxt = 1'b0;
          st_nxt  = (in_func == FUNC_SPLIT) ? S_COUNT : S_LOOK;
        end
      end
      S_LOOK: begin
        if (t_r < cnt_r) begin
          // Rotate the stored entries once through cell 0.
          fnd_nxt  = fnd_r | head_match;
          shift_en = 1'b1;
          wsel_en  = 1'b1;
          k_nxt    = k_r + CNT_W'(1);
          t_nxt    = t_r + CNT_W'(1);
        end else begin
          ov_nxt  = 1'b1;
          orl_nxt = 1'b1;
          of_nxt  = fnd_r;
          if (func_r == FUNC_INSERT && !fnd_r) begin
            if (cnt_r >= cap_eff) begin
              ons_nxt = 1'b1;
            end else begin
              wsel    = cnt_r;
              wsel_en = 1'b1;
              alt_stg = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
              orc_nxt = cnt_r + CNT_W'(1);
            end
          end
          stg_clr = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      S_COUNT: begin
        if (t_r < cnt_r) begin
          shift_en = 1'b1;
          wsel_en  = 1'b1;
          wsel     = cnt_r - CNT_W'(1);
          if (!head_moves) k_nxt = k_r + CNT_W'(1);
          t_nxt = t_r + CNT_W'(1);
        end else begin
          rem_nxt = k_r;
          mv_nxt  = cnt_r - k_r;
          t_nxt   = '0;
          k_nxt   = '0;
          st_nxt  = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (t_r < cnt_r) begin
          if (head_moves) begin
            w_nxt  = '0;
            st_nxt = S_EMIT;
          end else begin
            // Kept entry goes behind the entries already kept.
            shift_en = 1'b1;
            wsel_en  = 1'b1;
            k_nxt    = k_r + CNT_W'(1);
            t_nxt    = t_r + CNT_W'(1);
          end
        end else begin
          if (rem_r == cnt_r) begin
            ov_nxt  = 1'b1;
            orl_nxt = 1'b1;
            orc_nxt = rem_r;
          end
          cnt_nxt = rem_r;
          stg_clr = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        ov_nxt  = 1'b1;
        omv_nxt = 1'b1;
        oh_nxt  = head_hash;
        ow_nxt  = cq[0][WORD_W + WORD_W*w_r +: WORD_W];
        orc_nxt = rem_r;
        if (3'(w_r) == n_eff - 3'd1) begin
          orl_nxt  = (mv_r == CNT_W'(1));
          mv_nxt   = mv_r - CNT_W'(1);
          shift_en = 1'b1;
          t_nxt    = t_r + CNT_W'(1);
          st_nxt   = S_SPLIT;
        end else begin
          w_nxt = w_r + SW'(1);
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sidx_nxt = sidx_r;
    if (stg_clr) begin
      sidx_nxt = '0;
    end else if (accept && !in_word_last && (sidx_r < SW'(MAX_TUPLE_WORDS - 1))) begin
      sidx_nxt = sidx_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      sidx_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      sidx_r <= sidx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    mv_r  <= mv_nxt;
    w_r   <= w_nxt;
    fnd_r <= fnd_nxt;
    of_r  <= of_nxt;
    ons_r <= ons_nxt;
    omv_r <= omv_nxt;
    oh_r  <= oh_nxt;
    ow_r  <= ow_nxt;
    orl_r <= orl_nxt;
    orc_r <= orc_nxt;
    if (accept && in_word_last) begin
      func_r <= in_func;
      h_r    <= in_hash;
      mask_r <= in_split_mask;
      suf_r  <= in_split_suffix;
    end
    // The staging buffer starts empty, so missing words read as zero.
    if (!rst_n || stg_clr) begin
      for (int j = 0; j < MAX_TUPLE_WORDS; j++) stg_r[j] <= '0;
    end else if (accept) begin
      stg_r[sidx_r] <= in_word;
    end
  end

  assign out_valid           = ov_r;
  assign out_found           = of_r;
  assign out_bucket_full     = ons_r;
  assign out_moved_valid     = omv_r;
  assign out_moved_hash      = oh_r;
  assign out_moved_word      = ow_r;
  assign out_run_last        = orl_r;
  assign out_remaining_count = orc_r;

  // The stored count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_remaining_count <= 5'(MAX_ENTRIES)))
    else $error("remaining count above cell count");

  // A closing beat starts an operation that holds busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word_last) |=> busy)
    else $error("operation did not start");

  // Moved words never carry lookup flags.
  a_move_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_moved_valid) |-> (!out_found && !out_bucket_full))
    else $error("moved word with lookup flags");

endmodule
`default_nettype wire

// ----- tb/sv/hash_bucket_checker.sv -----
// Scoreboard for the hash bucket: watches the command, result and register
// ports, predicts every result beat and compares it. Depends on hbds_pkg.
module hash_bucket_checker
  import hbds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [63:0] in_hash,
  input  wire logic [63:0] in_word,
  input  wire logic        in_word_last,
  input  wire logic [63:0] in_split_mask,
  input  wire logic [63:0] in_split_suffix,
  input  wire logic        out_valid,
  input  wire logic        out_found,
  input  wire logic        out_bucket_full,
  input  wire logic        out_moved_valid,
  input  wire logic [63:0] out_moved_hash,
  input  wire logic [63:0] out_moved_word,
  input  wire logic        out_run_last,
  input  wire logic [4:0]  out_remaining_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               pending,
  output int               errors
);

  typedef struct packed {
    logic        found;
    logic        bucket_full;
    logic        moved_valid;
    logic [63:0] moved_hash;
    logic [63:0] moved_word;
    logic        run_last;
    logic [4:0]  remaining;
  } bucket_res_t;

  bucket_res_t expected_q[$];

  logic [2:0]  words_reg;
  logic [4:0]  cap_reg;
  logic [63:0] hashes[16];
  logic [63:0] tuples[16][4];
  logic [63:0] staged[4];
  int          held;
  int          stage_at;

  function automatic int words_used();
    if (words_reg == 0) return 1;
    if (words_reg > 4) return 4;
    return int'(words_reg);
  endfunction

  function automatic int cap_used();
    if (cap_reg == 0) return 1;
    if (cap_reg > 16) return 16;
    return int'(cap_reg);
  endfunction

  function automatic bit tuple_present(logic [63:0] h);
    int n;
    bit eq;
    n = words_used();
    for (int i = 0; i < held; i++) begin
      if (hashes[i] == h) begin
        eq = 1;
        for (int j = 0; j < n; j++)
          if (staged[j] != tuples[i][j]) eq = 0;
        if (eq) return 1;
      end
    end
    return 0;
  endfunction

  // Stage one word; on the last word run the operation and queue its results.
  task automatic predict_beat(logic [1:0] f, logic [63:0] h, logic [63:0] w,
                              logic last, logic [63:0] mask, logic [63:0] suf);
    bucket_res_t r;
    bucket_res_t moved[$];
    int n;
    int keep;
    bit hit;
    bit refused;
    if (stage_at > 3) stage_at = 3;
    staged[stage_at] = w;
    if (!last) begin
      if (stage_at < 3) stage_at++;
      return;
    end
    if (f == FUNC_SPLIT) begin
      n = words_used();
      keep = 0;
      for (int i = 0; i < held; i++) begin
        if ((hashes[i] & mask) == suf) begin
          for (int j = 0; j < n; j++) begin
            r = '0;
            r.moved_valid = 1;
            r.moved_hash = hashes[i];
            r.moved_word = tuples[i][j];
            moved.push_back(r);
          end
        end else begin
          hashes[keep] = hashes[i];
          tuples[keep] = tuples[i];
          keep++;
        end
      end
      held = keep;
      if (moved.size() == 0) begin
        r = '0;
        r.run_last = 1;
        r.remaining = 5'(held);
        moved.push_back(r);
      end else begin
        foreach (moved[x]) moved[x].remaining = 5'(held);
        moved[moved.size()-1].run_last = 1;
      end
      foreach (moved[x]) expected_q.push_back(moved[x]);
    end else begin
      // Any code other than split behaves as a lookup unless it is an insert.
      hit = tuple_present(h);
      refused = 0;
      if (f == FUNC_INSERT && !hit) begin
        if (held >= cap_used()) refused = 1;
        else begin
          hashes[held] = h;
          tuples[held] = staged;
          held++;
        end
      end
      r = '0;
      r.found = hit;
      r.bucket_full = refused;
      r.run_last = 1;
      r.remaining = 5'(held);
      expected_q.push_back(r);
    end
    for (int j = 0; j < 4; j++) staged[j] = '0;
    stage_at = 0;
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    bucket_res_t want;
    if (!rst_n) begin
      words_reg <= 1;
      cap_reg <= 16;
      held = 0;
      stage_at = 0;
      errors = 0;
      for (int j = 0; j < 4; j++) staged[j] = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TUPLE_WORDS) words_reg <= pwdata[2:0];
        else cap_reg <= pwdata[4:0];
      end
      if (start && !busy)
        predict_beat(in_func, in_hash, in_word, in_word_last, in_split_mask,
                     in_split_suffix);
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (want.found != out_found)
            report("found", 64'(want.found), 64'(out_found));
          if (want.bucket_full != out_bucket_full)
            report("bucket_full", 64'(want.bucket_full), 64'(out_bucket_full));
          if (want.moved_valid != out_moved_valid)
            report("moved_valid", 64'(want.moved_valid), 64'(out_moved_valid));
          if (want.moved_hash != out_moved_hash)
            report("moved_hash", want.moved_hash, out_moved_hash);
          if (want.moved_word != out_moved_word)
            report("moved_word", want.moved_word, out_moved_word);
          if (want.run_last != out_run_last)
            report("run_last", 64'(want.run_last), 64'(out_run_last));
          if (want.remaining != out_remaining_count)
            report("remaining_count", 64'(want.remaining), 64'(out_remaining_count));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the hash bucket testbench: clock, reset, command and register
// stimulus, verdict. Depends on hbds_pkg, hash_bucket_checker and the block.
module testbench;
  import hbds_pkg::*;

  // The unused opcode; the block must treat it as a plain lookup.
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic [1:0]  in_func = '0;
  logic [63:0] in_hash = '0;
  logic [63:0] in_word = '0;
  logic        in_word_last = 0;
  logic [63:0] in_split_mask = '0;
  logic [63:0] in_split_suffix = '0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  wire         busy;
  wire         out_valid;
  wire         out_found;
  wire         out_bucket_full;
  wire         out_moved_valid;
  wire [63:0]  out_moved_hash;
  wire [63:0]  out_moved_word;
  wire         out_run_last;
  wire [4:0]   out_remaining_count;
  wire [31:0]  prdata;
  wire         pready;
  int          pending;
  int          errors;
  int          cycles = 0;

  // Percentage of beats preceded by idle cycles on the command side.
  int          gap_pct = 0;
  int          words_now = 1;
  logic [63:0] pool_hash[8];
  logic [63:0] pool_word[8][4];

  hash_bucket_dedup_split_top dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_hash, .in_word, .in_word_last,
    .in_split_mask, .in_split_suffix, .out_valid, .out_found, .out_bucket_full,
    .out_moved_valid, .out_moved_hash, .out_moved_word, .out_run_last,
    .out_remaining_count, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready
  );

  hash_bucket_checker chk (
    .clk, .rst_n, .start, .busy, .in_func, .in_hash, .in_word, .in_word_last,
    .in_split_mask, .in_split_suffix, .out_valid, .out_found, .out_bucket_full,
    .out_moved_valid, .out_moved_hash, .out_moved_word, .out_run_last,
    .out_remaining_count, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending, .errors
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Present one beat and hold it until the block takes it. Busy only moves on
  // a rising edge, so its value at the falling edge is what the next rising
  // edge will see.
  task automatic send_beat(logic [1:0] f, logic [63:0] h, logic [63:0] w,
                           logic last, logic [63:0] mask, logic [63:0] suf);
    bit taken;
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_func <= f;
    in_hash <= h;
    in_word <= w;
    in_word_last <= last;
    in_split_mask <= mask;
    in_split_suffix <= suf;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // One tuple of nw words; only the last beat's func, hash and split fields
  // matter, so the earlier beats carry random junk there.
  task automatic run_op(logic [1:0] f, logic [63:0] h, logic [63:0] w[4], int nw,
                        logic [63:0] mask, logic [63:0] suf);
    for (int j = 0; j < nw; j++) begin
      if (j == nw - 1) send_beat(f, h, w[j > 3 ? 3 : j], 1, mask, suf);
      else send_beat(2'($urandom_range(3)), rand64(), w[j > 3 ? 3 : j], 0,
                     rand64(), rand64());
    end
  endtask

  // Registers change only with the bucket quiet: every expected beat seen,
  // then enough cycles for a split's closing step, then busy low.
  task automatic write_reg(logic idx, logic [31:0] val);
    start <= 0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
    if (idx == REG_TUPLE_WORDS)
      words_now = (val[2:0] == 0) ? 1 : (val[2:0] > 4 ? 4 : val[2:0]);
  endtask

  // Random operation: mostly inserts of pooled tuples so that lookups hit,
  // the bucket fills and splits have something to move.
  task automatic random_op();
    logic [63:0] w[4];
    logic [63:0] h;
    logic [63:0] mask;
    logic [1:0]  f;
    int          slot;
    int          pick;
    int          nw;
    slot = $urandom_range(7);
    if ($urandom_range(99) < 40) begin
      pool_hash[slot] = $urandom_range(1) ? rand64() : 64'($urandom_range(7));
      for (int j = 0; j < 4; j++) pool_word[slot][j] = rand64();
    end
    h = pool_hash[slot];
    w = pool_word[slot];
    // Same hash with a different tuple must not be reported as found.
    if ($urandom_range(99) < 10) w[$urandom_range(words_now - 1)] = rand64();
    nw = words_now;
    if ($urandom_range(99) < 10) nw = $urandom_range(1, 6);
    pick = $urandom_range(99);
    if (pick < 55) f = FUNC_INSERT;
    else if (pick < 75) f = FUNC_LOOKUP;
    else if (pick < 82) f = FUNC_SPARE;
    else f = FUNC_SPLIT;
    case ($urandom_range(4))
      0: mask = 64'h1;
      1: mask = 64'h3;
      2: mask = '0;
      3: mask = '1;
      default: mask = rand64();
    endcase
    if ($urandom_range(1)) h = pool_hash[$urandom_range(7)] & mask;
    else if (f == FUNC_SPLIT) h = rand64() & mask;
    // For a split the hash field carries a random value; the suffix is h.
    run_op(f, f == FUNC_SPLIT ? rand64() : (($urandom_range(1)) ?
           pool_hash[slot] : h), w, nw, mask, h);
  endtask

  initial begin
    logic [63:0] w[4];
    int          caps[6];
    int          tws[6];
    int          gaps[4];
    caps = '{16, 3, 0, 31, 1, 16};
    tws = '{4, 2, 0, 7, 3, 1};
    gaps = '{0, 68, 0, 33};
    for (int i = 0; i < 8; i++) begin
      pool_hash[i] = rand64();
      for (int j = 0; j < 4; j++) pool_word[i][j] = rand64();
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: field extremes, every opcode and the odd cases.
    write_reg(REG_TUPLE_WORDS, 1);
    write_reg(REG_CAPACITY, 2);
    w = '{default: '0};
    run_op(FUNC_INSERT, '0, w, 1, '0, '0);
    run_op(FUNC_INSERT, '0, w, 1, '0, '0);          // duplicate, found
    w = '{default: '1};
    run_op(FUNC_INSERT, '1, w, 1, '1, '1);
    run_op(FUNC_INSERT, 64'h5, w, 1, '0, '0);        // full, insert refused
    run_op(FUNC_LOOKUP, '1, w, 1, '0, '0);
    run_op(FUNC_SPARE, '1, w, 1, '0, '0);
    run_op(FUNC_LOOKUP, '1, w, 6, '0, '0);           // extra words overwrite
    run_op(FUNC_SPLIT, '0, w, 1, '1, 64'h1234);      // nothing moves
    run_op(FUNC_SPLIT, '0, w, 1, 64'h1, 64'h1);      // moves the all-ones entry
    write_reg(REG_CAPACITY, 16);
    write_reg(REG_TUPLE_WORDS, 4);
    w = '{64'hA5A5_0000_FFFF_1111, 64'h1, 64'h2, 64'h3};
    run_op(FUNC_INSERT, 64'hDEAD, w, 4, '0, '0);
    run_op(FUNC_INSERT, 64'hBEEF, w, 2, '0, '0);     // missing words read zero
    w[2] = '0;
    w[3] = '0;
    run_op(FUNC_LOOKUP, 64'hBEEF, w, 2, '0, '0);
    run_op(FUNC_SPLIT, '0, w, 1, '0, '0);            // everything moves

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_TUPLE_WORDS, tws[p]);
      write_reg(REG_CAPACITY, caps[p]);
      gap_pct = gaps[p % 4];
      repeat (8) random_op();
    end

    start <= 0;
    wait (pending == 0);
    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

// ----- hash_bucket_dedup_split_top.f -----
rtl/hbds_pkg.sv
rtl/hbds_cell.sv
rtl/hash_bucket_dedup_split_top.sv
tb/sv/hash_bucket_checker.sv
tb/sv/testbench.sv
